>>> design/mexp_pkg.sv
// Shared types, widths and operation codes for the modular exponentiation core.
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0] word_t;

    // Operand selection for the shared modular multiplier
    localparam logic [1:0] OP_REDUCE = 2'd0;  // 1 * square (reduces the raw base)
    localparam logic [1:0] OP_MUL    = 2'd1;  // square * accum
    localparam logic [1:0] OP_SQR    = 2'd2;  // square * square

    typedef struct packed {
        logic       load;
        logic       start;
        logic [1:0] op;
        logic       wb_square;
        logic       wb_accum;
        logic       shift_exp;
    } mexp_cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic exp_last;
        logic mul_busy;
        logic mul_done;
    } mexp_status_t;

endpackage

>>> design/mexp_modmul.sv
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
`timescale 1ns / 1ps

module mexp_modmul import mexp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t a,
    input  word_t b,
    input  word_t modulus,
    output logic  busy,
    output logic  done,
    output word_t result
);

    localparam int EW = OPERAND_WIDTH + 2;

    logic             run_reg;
    logic             run_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    word_t            r_reg;
    word_t            a_reg;
    word_t            b_reg;
    word_t            r_step;

    logic [EW-1:0] t;
    logic [EW-1:0] m1;
    logic [EW-1:0] m2;
    logic [EW-1:0] d1;
    logic [EW-1:0] d2;
    logic          mod_zero;

    // r < m and a < m keep 2r + a below 3m, so two subtractions at most
    always_comb
    begin
        t        = {1'b0, r_reg, 1'b0} + (b_reg[OPERAND_WIDTH-1] ? EW'(a_reg) : '0);
        m1       = EW'(modulus);
        m2       = {1'b0, modulus, 1'b0};
        d1       = t - m1;
        d2       = t - m2;
        mod_zero = (modulus == '0);
        if (mod_zero)
        begin
            r_step = t[OPERAND_WIDTH-1:0];
        end
        else if (t >= m2)
        begin
            r_step = d2[OPERAND_WIDTH-1:0];
        end
        else if (t >= m1)
        begin
            r_step = d1[OPERAND_WIDTH-1:0];
        end
        else
        begin
            r_step = t[OPERAND_WIDTH-1:0];
        end
    end

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(OPERAND_WIDTH - 1);
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            a_reg <= a;
            b_reg <= b;
        end
        else if (run_reg)
        begin
            r_reg <= r_step;
            b_reg <= {b_reg[OPERAND_WIDTH-2:0], 1'b0};
        end
    end

    assign busy   = run_reg;
    assign done   = done_reg;
    assign result = r_reg;

    a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg && !start && cnt_reg == '0 |=> done_reg && !run_reg)
        else $error("modmul: last step not followed by done");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("modmul: done while still running");

endmodule

>>> design/mexp_dp.sv
// Datapath: modulus, square, accumulator and exponent registers around the multiplier.
`timescale 1ns / 1ps

module mexp_dp import mexp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  word_t        cfg_wr_data,
    input  word_t        base,
    input  word_t        exponent,
    input  mexp_cmd_t    cmd,
    output mexp_status_t status,
    output word_t        power_mod
);

    word_t modulus_reg;
    word_t square_reg;
    word_t accum_reg;
    word_t exp_reg;
    word_t op_a;
    word_t op_b;
    word_t mul_result;
    logic  mul_busy;
    logic  mul_done;

    always_comb
    begin
        unique case (cmd.op)
            OP_REDUCE:
            begin
                op_a = word_t'(1);
                op_b = square_reg;
            end
            OP_MUL:
            begin
                op_a = square_reg;
                op_b = accum_reg;
            end
            OP_SQR:
            begin
                op_a = square_reg;
                op_b = square_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    mexp_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.start),
        .a       (op_a),
        .b       (op_b),
        .modulus (modulus_reg),
        .busy    (mul_busy),
        .done    (mul_done),
        .result  (mul_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= word_t'(1);
        end
        else if (cfg_wr_en)
        begin
            modulus_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            square_reg <= base;
            exp_reg    <= exponent;
            accum_reg  <= word_t'(1);
        end
        else
        begin
            if (cmd.wb_square)
            begin
                square_reg <= mul_result;
            end
            if (cmd.wb_accum)
            begin
                accum_reg <= mul_result;
            end
            if (cmd.shift_exp)
            begin
                exp_reg <= {1'b0, exp_reg[OPERAND_WIDTH-1:1]};
            end
        end
    end

    always_comb
    begin
        status.exp_zero = (exp_reg == '0);
        status.exp_lsb  = exp_reg[0];
        status.exp_last = (exp_reg[OPERAND_WIDTH-1:1] == '0);
        status.mul_busy = mul_busy;
        status.mul_done = mul_done;
    end

    assign power_mod = accum_reg;

endmodule

>>> design/mexp_ctrl.sv
// Controller: sequences base reduction, multiply and square steps per exponent bit.
`timescale 1ns / 1ps

module mexp_ctrl import mexp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  mexp_status_t status,
    output mexp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_RED   = 3'd2;
    localparam logic [2:0] S_BIT   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_SQR   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.op     = OP_REDUCE;
        state_next = state_reg;
        in_stall   = (state_reg != S_IDLE);
        out_valid  = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // zero exponent: result stays at the unreduced 1
                if (status.exp_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_REDUCE;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                if (status.mul_done)
                begin
                    cmd.wb_square = 1'b1;
                    state_next    = S_BIT;
                end
            end
            S_BIT:
            begin
                cmd.start = 1'b1;
                if (status.exp_lsb)
                begin
                    cmd.op     = OP_MUL;
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.op     = OP_SQR;
                    state_next = S_SQR;
                end
            end
            S_MUL:
            begin
                if (status.mul_done)
                begin
                    cmd.wb_accum = 1'b1;
                    // last set bit: the final squaring is never used
                    if (status.exp_last)
                    begin
                        cmd.shift_exp = 1'b1;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.op     = OP_SQR;
                        state_next = S_SQR;
                    end
                end
            end
            S_SQR:
            begin
                if (status.mul_done)
                begin
                    cmd.wb_square = 1'b1;
                    cmd.shift_exp = 1'b1;
                    state_next    = S_BIT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_out_exp_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status.exp_zero)
        else $error("ctrl: result offered with exponent bits left");

    a_start_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !status.mul_busy)
        else $error("ctrl: multiplier started while busy");

endmodule

>>> design/modular_exponentiation_core.sv
// Top level: modular exponentiation by right-to-left square-and-multiply.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------
//   in       | in_valid / in_stall  | base[31:0], exponent[31:0]
//   out      | out_valid / out_stall| power_mod[31:0]
//   config   | cfg_wr_en            | cfg_wr_data[31:0] (modulus)
//
// One beat at a time. Exponent zero: the result is offered straight after the check.
// Otherwise the base is reduced first, then per scanned exponent bit a square for
// a clear bit, a multiply then a square for a set bit, and only a multiply for the top set
// bit, whose squaring is skipped; the result is offered after that.
// All steps share the one interleaved modular multiplier, which takes one bit per cycle.
// Reset sets the modulus to 1 and the controller to idle.
// in_stall is high from accept until the result beat leaves; out_stall holds the result.
`timescale 1ns / 1ps

module modular_exponentiation_core import mexp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_wr_en,
    input  word_t cfg_wr_data,
    input  logic  in_valid,
    output logic  in_stall,
    input  word_t base,
    input  word_t exponent,
    output logic  out_valid,
    input  logic  out_stall,
    output word_t power_mod
);

    mexp_cmd_t    cmd;
    mexp_status_t status;

    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mexp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .base        (base),
        .exponent    (exponent),
        .cmd         (cmd),
        .status      (status),
        .power_mod   (power_mod)
    );

endmodule

>>> tb/mexp_checker.sv
// Scoreboard for the modular exponentiation core: predicts each result and compares.
`timescale 1ns / 1ps

module mexp_checker import mexp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_wr_en,
    input  word_t cfg_wr_data,
    input  logic  in_valid,
    input  logic  in_stall,
    input  word_t base,
    input  word_t exponent,
    input  logic  out_valid,
    input  logic  out_stall,
    input  word_t power_mod,
    output int    outstanding,
    output int    errors
);

    typedef logic [2*OPERAND_WIDTH-1:0] wide_t;

    word_t modulus;
    word_t expected_powers[$];

    // a zero modulus means no reduction: products wrap to the operand width
    function automatic wide_t reduce_product(wide_t p, word_t m);
        if (m == '0)
            return wide_t'(p[OPERAND_WIDTH-1:0]);
        return p % wide_t'(m);
    endfunction

    // right-to-left square-and-multiply; the raw base is squared unreduced at first
    function automatic word_t predict_power(word_t b, word_t e, word_t m);
        wide_t sq;
        wide_t acc;
        word_t bits_left;
        sq        = wide_t'(b);
        acc       = wide_t'(1);
        bits_left = e;
        while (bits_left != '0)
        begin
            if (bits_left[0])
                acc = reduce_product(acc * sq, m);
            sq = reduce_product(sq * sq, m);
            bits_left = bits_left >> 1;
        end
        return acc[OPERAND_WIDTH-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus <= word_t'(1);
            expected_powers.delete();
            outstanding <= 0;
            errors <= 0;
        end
        else
        begin : monitor
            word_t want;
            if (cfg_wr_en)
                modulus <= cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                if (expected_powers.size() == 0)
                begin
                    $error("power_mod: beat with nothing expected, actual %h", power_mod);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_powers.pop_front();
                    if (power_mod !== want)
                    begin
                        $error("power_mod: expected %h, actual %h", want, power_mod);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_powers.push_back(predict_power(base, exponent, modulus));
            outstanding <= expected_powers.size();
        end
    end

endmodule

>>> tb/tb.sv
// Testbench top for the modular exponentiation core: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb;
    import mexp_pkg::*;

    localparam int QUIET_LIMIT    = 20000;  // cycles with no beat on either channel
    localparam int PRESSURE_BEAT  = 60;     // result count at which the long hold-off starts
    localparam int PRESSURE_HOLD  = 3000;
    localparam int DRAIN_CYCLES   = 2200;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_wr_en;
    word_t cfg_wr_data;
    logic  in_valid;
    logic  in_stall;
    word_t base;
    word_t exponent;
    logic  out_valid;
    logic  out_stall;
    word_t power_mod;
    int    outstanding;
    int    errors;
    int    quiet_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    modular_exponentiation_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .base        (base),
        .exponent    (exponent),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .power_mod   (power_mod)
    );

    mexp_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .base        (base),
        .exponent    (exponent),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .power_mod   (power_mod),
        .outstanding (outstanding),
        .errors      (errors)
    );

    // mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    task automatic send_beat(input word_t b, input word_t e);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        base     <= b;
        exponent <= e;
        do
            @(posedge clk);
        while (in_stall);
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk) in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // only called once the core is idle
    task automatic write_modulus(input word_t m);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk) cfg_wr_en <= 1'b0;
    endtask

    function automatic word_t rand_base();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return word_t'($urandom_range(1, 3));
            default: return word_t'($urandom);
        endcase
    endfunction

    // short exponents dominate to keep the run length sensible
    function automatic word_t rand_exponent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return word_t'(1);
            2, 3:    return word_t'($urandom);
            default: return word_t'($urandom) >> $urandom_range(4, 31);
        endcase
    endfunction

    function automatic word_t rand_modulus(input int ph);
        case (ph % 6)
            0:       return word_t'($urandom) | 32'h8000_0000;
            1:       return word_t'($urandom_range(2, 1000));
            2:       return word_t'(1);
            3:       return '0;
            4:       return word_t'($urandom);
            default: return '1;
        endcase
    endfunction

    initial
    begin : stimulus
        int n_items;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        base        = '0;
        exponent    = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // modulus still at its reset value of 1: exponent zero gives 1 unreduced
        send_beat(32'd7, 32'd0);
        send_beat(32'd7, 32'd5);
        send_beat('1, '1);
        drain();

        write_modulus('1);
        send_beat('0, '0);
        send_beat('0, 32'd1);
        send_beat(32'd1, '1);
        send_beat('1, 32'd1);
        send_beat('1, '0);
        send_beat(32'hFFFF_FFFE, '1);
        send_beat(32'h1234_5678, 32'h8000_0000);
        send_beat(32'd3, 32'd31);
        send_beat(32'hDEAD_BEEF, '1);
        drain();

        // zero modulus: plain wrap-around arithmetic
        write_modulus('0);
        send_beat(32'd3, 32'd40);
        send_beat('1, '1);
        send_beat(32'h0001_0000, 32'd2);
        send_beat(32'h8000_0000, 32'd1);
        drain();

        // base at, above and just below the modulus
        write_modulus(32'd13);
        send_beat(32'd100, 32'd7);
        send_beat(32'd13, 32'd5);
        send_beat(32'd12, '1);
        send_beat('1, 32'h5555_5555);
        drain();

        write_modulus(32'd2);
        send_beat(32'd5, 32'hAAAA_AAAA);
        send_beat(32'd4, 32'd3);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_modulus(rand_modulus(ph));
            n_items = (ph == 0) ? 70 : 38;
            for (int i = 0; i < n_items; i++)
                send_beat(rand_base(), rand_exponent());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : receiver
        int hold_left;
        int beats_taken;
        bit pressure_done;
        hold_left     = 0;
        beats_taken   = 0;
        pressure_done = 1'b0;
        out_stall     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                beats_taken++;
            @(negedge clk);
            if (hold_left > 0)
                hold_left--;
            else if (beats_taken >= PRESSURE_BEAT && !pressure_done)
            begin
                // result sits while the sender keeps offering, so the core backs up
                hold_left     = PRESSURE_HOLD;
                pressure_done = 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
                hold_left = gap_len();
            out_stall <= (hold_left > 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

>>> filelist.f
design/mexp_pkg.sv
design/mexp_modmul.sv
design/mexp_dp.sv
design/mexp_ctrl.sv
design/modular_exponentiation_core.sv
tb/mexp_checker.sv
tb/tb.sv
